### sv/a64rofm_pkg.sv
// ----------------------------------------------------------------------------
// a64rofm_pkg
// Types, constants and the instruction class decoder for the A64 register
// operand field map.
// ----------------------------------------------------------------------------
package a64rofm_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned REG_W     = 5;
  localparam int unsigned NUM_GPR   = 31;
  localparam int unsigned NUM_SLOTS = 4;

  // operand slot order: rd, rn, ra, rm
  localparam int unsigned SLOT_RD = 0;
  localparam int unsigned SLOT_RN = 1;
  localparam int unsigned SLOT_RA = 2;
  localparam int unsigned SLOT_RM = 3;
  localparam int unsigned SLOT_LSB [NUM_SLOTS] = '{0, 5, 10, 16};

  localparam logic [REG_W-1:0] REG_ZR_SP = 5'd31;
  localparam logic [REG_W-1:0] REG_X18   = 5'd18;

  // role bits
  localparam logic [1:0] ROLE_NONE = 2'b00;
  localparam logic [1:0] ROLE_R    = 2'b01;
  localparam logic [1:0] ROLE_W    = 2'b10;
  localparam logic [1:0] ROLE_RW   = 2'b11;

  // load/store group masks
  localparam logic [31:0] LS_SIMD_STRUCT_MASK = 32'hBE000000;
  localparam logic [31:0] LS_SIMD_STRUCT_VAL  = 32'h0C000000;
  localparam logic [31:0] LS_EXCL_MASK        = 32'h3F000000;
  localparam logic [31:0] LS_EXCL_VAL         = 32'h08000000;
  localparam logic [31:0] LS_LIT_MASK         = 32'h3B000000;
  localparam logic [31:0] LS_LIT_VAL          = 32'h18000000;
  localparam logic [31:0] LS_PAIR_MASK        = 32'h3A000000;
  localparam logic [31:0] LS_PAIR_VAL         = 32'h28000000;
  localparam logic [31:0] LS_REG_VAL          = 32'h38000000;
  localparam logic [31:0] SIMD_COPY_MASK      = 32'h9FE08400;
  localparam logic [31:0] SIMD_COPY_VAL       = 32'h0E000400;

  localparam logic [9:0] OP_SYSREG   = 10'h354;
  localparam logic [7:0] OP_EXCEPT   = 8'hd4;
  localparam logic [6:0] OP_BR_REG   = 7'h6b;
  localparam logic [4:0] OP_FP_INT   = 5'h1e;

  // encoding class fields
  localparam logic [4:0] DPI_PCREL       = 5'h10;
  localparam logic [5:0] DPI_ADDSUB      = 6'h22;
  localparam logic [5:0] DPI_ADDSUB_TAG  = 6'h23;
  localparam logic [5:0] DPI_LOGICAL     = 6'h24;
  localparam logic [5:0] DPI_MOVEWIDE    = 6'h25;
  localparam logic [5:0] DPI_BITFIELD    = 6'h26;
  localparam logic [5:0] DPI_EXTRACT     = 6'h27;
  localparam logic [1:0] OPC_MOVK        = 2'd3;
  localparam logic [1:0] OPC_BFM         = 2'd1;
  localparam logic [1:0] OPC_BF_RSVD     = 2'd3;
  localparam logic [4:0] BR_IMM          = 5'h05;
  localparam logic [6:0] BR_COND         = 7'h2a;
  localparam logic [5:0] BR_CMP          = 6'h1a;
  localparam logic [5:0] BR_TEST         = 6'h1b;
  localparam logic [1:0] LS_OP2_UNSCALED = 2'd0;
  localparam logic [1:0] LS_OP2_REGOFF   = 2'd2;
  localparam logic [1:0] LS_OPC_STR      = 2'd0;
  localparam logic [1:0] LS_OPC_PRFM     = 2'd2;
  localparam logic [1:0] LS_SIZE_X       = 2'd3;
  localparam logic [4:0] DPR_LOGICAL     = 5'h0a;
  localparam logic [4:0] DPR_ADDSUB      = 5'h0b;
  localparam logic [4:0] DPR_MISC        = 5'h1a;
  localparam logic [4:0] DPR_3SRC        = 5'h1b;
  localparam logic [2:0] MISC_ADC        = 3'd0;
  localparam logic [2:0] MISC_CCMP       = 3'd2;
  localparam logic [2:0] MISC_CSEL       = 3'd4;
  localparam logic [2:0] MISC_DP         = 3'd6;
  localparam logic [2:0] FPI_SCVTF       = 3'd2;
  localparam logic [2:0] FPI_UCVTF       = 3'd3;
  localparam logic [2:0] FPI_FMOV_TO_FP  = 3'd7;
  localparam logic [3:0] COPY_DUP_ELEM   = 4'h0;
  localparam logic [3:0] COPY_DUP_GEN    = 4'h1;
  localparam logic [3:0] COPY_INS        = 4'h3;
  localparam logic [3:0] COPY_SMOV       = 4'h5;
  localparam logic [3:0] COPY_UMOV       = 4'h7;

  typedef enum logic [2:0] {
    PK_NONE = 3'd0,
    PK_ADR  = 3'd1,
    PK_ADRP = 3'd2,
    PK_CBZ  = 3'd3,
    PK_TBZ  = 3'd4,
    PK_LIT  = 3'd5
  } pc_kind_e;

  typedef enum logic [1:0] {
    HZ_NONE   = 2'd0,
    HZ_SP     = 2'd1,
    HZ_NOFALL = 2'd2
  } hz_kind_e;

  // per-slot requested role; nonzero means the encoding names that slot
  typedef struct packed {
    logic                         ok;
    pc_kind_e                     pc;
    hz_kind_e                     hz;
    logic [NUM_SLOTS-1:0][1:0]    req;
  } dec_t;

  function automatic dec_t decode_word(logic [WORD_W-1:0] w);
    dec_t       d;
    logic [3:0] op0;
    logic [1:0] opc;
    logic       rd31;
    logic       rn31;
    logic       pf;
    logic       gp;
    logic [1:0] trole;
    logic [1:0] op2;
    logic       wb;
    d.ok  = 1'b0;
    d.pc  = PK_NONE;
    d.hz  = HZ_NONE;
    d.req = '0;
    op0   = w[28:25];
    opc   = w[30:29];
    rd31  = (w[4:0] == REG_ZR_SP);
    rn31  = (w[9:5] == REG_ZR_SP);
    pf    = (w[31:30] == LS_SIZE_X) && !w[26] && (w[23:22] == LS_OPC_PRFM);
    gp    = !w[26] && !pf;
    trole = (w[23:22] != LS_OPC_STR) ? ROLE_W : ROLE_R;
    op2   = w[11:10];
    wb    = 1'b0;

    if (op0[3:1] == 3'b100) begin
      // data processing, immediate
      if (w[28:24] == DPI_PCREL) begin
        d.ok = 1'b1;
        d.pc = w[31] ? PK_ADRP : PK_ADR;
        d.req[SLOT_RD] = ROLE_W;
      end else begin
        unique case (w[28:23]) inside
          DPI_ADDSUB, DPI_ADDSUB_TAG: begin
            d.ok = 1'b1;
            if (!w[29] && rd31) d.hz = HZ_SP;
            d.req[SLOT_RD] = ROLE_W;
            d.req[SLOT_RN] = ROLE_R;
          end
          DPI_LOGICAL: begin
            d.ok = 1'b1;
            d.req[SLOT_RD] = ROLE_W;
            d.req[SLOT_RN] = ROLE_R;
          end
          DPI_MOVEWIDE: begin
            d.ok = 1'b1;
            d.req[SLOT_RD] = (opc == OPC_MOVK) ? ROLE_RW : ROLE_W;
          end
          DPI_BITFIELD: begin
            if (opc != OPC_BF_RSVD) begin
              d.ok = 1'b1;
              d.req[SLOT_RD] = (opc == OPC_BFM) ? ROLE_RW : ROLE_W;
              d.req[SLOT_RN] = ROLE_R;
            end
          end
          DPI_EXTRACT: begin
            d.ok = 1'b1;
            d.req[SLOT_RD] = ROLE_W;
            d.req[SLOT_RN] = ROLE_R;
            d.req[SLOT_RM] = ROLE_R;
          end
          default: d.ok = 1'b0;
        endcase
      end
    end else if (op0[3:1] == 3'b101) begin
      // branches, exceptions, system
      if (w[30:26] == BR_IMM || w[31:25] == BR_COND || w[31:24] == OP_EXCEPT) begin
        d.ok = 1'b1;
      end else if (w[31:22] == OP_SYSREG) begin
        d.ok = 1'b1;
        d.req[SLOT_RD] = w[21] ? ROLE_W : ROLE_R;
      end else if (w[31:25] == OP_BR_REG) begin
        d.ok = 1'b1;
        d.hz = HZ_NOFALL;
        d.req[SLOT_RN] = ROLE_R;
      end else if (w[30:25] == BR_CMP || w[30:25] == BR_TEST) begin
        d.ok = 1'b1;
        d.pc = (w[30:25] == BR_CMP) ? PK_CBZ : PK_TBZ;
        d.req[SLOT_RD] = ROLE_R;
      end
    end else if (op0[2] && !op0[0]) begin
      // loads and stores
      if ((w & LS_SIMD_STRUCT_MASK) == LS_SIMD_STRUCT_VAL) begin
        d.ok = 1'b1;
        if (w[23] && rn31) d.hz = HZ_SP;
        d.req[SLOT_RN] = w[23] ? ROLE_RW : ROLE_R;
        if (w[23]) d.req[SLOT_RM] = ROLE_R;
      end else if ((w & LS_EXCL_MASK) == LS_EXCL_VAL) begin
        d.ok = 1'b1;
        d.req[SLOT_RN] = ROLE_R;
        d.req[SLOT_RD] = w[22] ? ROLE_W : ROLE_R;
        d.req[SLOT_RA] = w[22] ? ROLE_W : ROLE_R;
        if (!w[22] && !w[23]) d.req[SLOT_RM] = ROLE_W;
      end else if ((w & LS_LIT_MASK) == LS_LIT_VAL) begin
        d.ok = 1'b1;
        if (!w[26]) begin
          d.pc = PK_LIT;
          d.req[SLOT_RD] = ROLE_W;
        end
      end else if ((w & LS_PAIR_MASK) == LS_PAIR_VAL) begin
        d.ok = 1'b1;
        wb = w[23];
        if (wb && rn31) d.hz = HZ_SP;
        d.req[SLOT_RN] = wb ? ROLE_RW : ROLE_R;
        if (!w[26]) begin
          d.req[SLOT_RD] = w[22] ? ROLE_W : ROLE_R;
          d.req[SLOT_RA] = w[22] ? ROLE_W : ROLE_R;
        end
      end else if ((w & LS_PAIR_MASK) == LS_REG_VAL) begin
        if (w[24]) begin
          d.ok = 1'b1;
          d.req[SLOT_RN] = ROLE_R;
          if (gp) d.req[SLOT_RD] = trole;
        end else if (w[21]) begin
          if (op2 == LS_OP2_REGOFF || op2 == LS_OP2_UNSCALED) begin
            d.ok = 1'b1;
            d.req[SLOT_RN] = ROLE_R;
            d.req[SLOT_RM] = ROLE_R;
            if (gp) d.req[SLOT_RD] = (op2 == LS_OP2_REGOFF) ? trole : ROLE_W;
          end
        end else if (op2 != LS_OP2_REGOFF) begin
          d.ok = 1'b1;
          wb = op2[0];
          if (wb && rn31) d.hz = HZ_SP;
          d.req[SLOT_RN] = wb ? ROLE_RW : ROLE_R;
          if (gp) d.req[SLOT_RD] = trole;
        end
      end
    end else if (op0[2:0] == 3'b101) begin
      // data processing, register
      unique case (w[28:24]) inside
        DPR_LOGICAL, DPR_ADDSUB: begin
          d.ok = 1'b1;
          if (w[24] && w[21] && !w[29] && rd31) d.hz = HZ_SP;
          d.req[SLOT_RD] = ROLE_W;
          d.req[SLOT_RN] = ROLE_R;
          d.req[SLOT_RM] = ROLE_R;
        end
        DPR_3SRC: begin
          d.ok = 1'b1;
          d.req[SLOT_RD] = ROLE_W;
          d.req[SLOT_RN] = ROLE_R;
          d.req[SLOT_RM] = ROLE_R;
          d.req[SLOT_RA] = ROLE_R;
        end
        DPR_MISC: begin
          unique case (w[23:21]) inside
            MISC_ADC, MISC_CSEL: begin
              d.ok = 1'b1;
              d.req[SLOT_RD] = ROLE_W;
              d.req[SLOT_RN] = ROLE_R;
              d.req[SLOT_RM] = ROLE_R;
            end
            MISC_CCMP: begin
              d.ok = 1'b1;
              d.req[SLOT_RN] = ROLE_R;
              if (!w[11]) d.req[SLOT_RM] = ROLE_R;
            end
            MISC_DP: begin
              d.ok = 1'b1;
              d.req[SLOT_RD] = ROLE_W;
              d.req[SLOT_RN] = ROLE_R;
              if (!w[30]) d.req[SLOT_RM] = ROLE_R;
            end
            default: d.ok = 1'b0;
          endcase
        end
        default: d.ok = 1'b0;
      endcase
    end else if (op0[2:0] == 3'b111) begin
      // scalar FP and Advanced SIMD
      d.ok = 1'b1;
      if (!w[30] && w[28:24] == OP_FP_INT && (!w[21] || w[15:10] == 6'd0)) begin
        if (w[18:16] == FPI_SCVTF || w[18:16] == FPI_UCVTF ||
            w[18:16] == FPI_FMOV_TO_FP) begin
          d.req[SLOT_RN] = ROLE_R;
        end else begin
          d.req[SLOT_RD] = ROLE_W;
        end
      end else if ((w & SIMD_COPY_MASK) == SIMD_COPY_VAL && !w[29]) begin
        unique case (w[14:11]) inside
          COPY_DUP_ELEM:          d.ok = 1'b1;
          COPY_DUP_GEN, COPY_INS: d.req[SLOT_RN] = ROLE_R;
          COPY_SMOV, COPY_UMOV:   d.req[SLOT_RD] = ROLE_W;
          default:                d.ok = 1'b0;
        endcase
      end
    end

    if (!d.ok) begin
      d.pc  = PK_NONE;
      d.hz  = HZ_NONE;
      d.req = '0;
    end
    return d;
  endfunction

endpackage

### sv/a64_register_operand_field_map.sv
// ----------------------------------------------------------------------------
// a64_register_operand_field_map
// Classifies A64 instruction words, maps their general register operands and
// rewrites every x18 operand slot with a replacement register number.
// ----------------------------------------------------------------------------
// Takes one instruction beat per clock while s_axis_tready_o is high and
// returns one result beat per input beat, in order. The work is split over
// three register stages: class decode, then register mask and x18 roles,
// then the output register with the rewritten word. Every stage holds its
// beat while the stage after it is full and stalled, so back-pressure
// ripples up to s_axis_tready_o without losing a beat; a full pipeline
// sustains one beat per cycle while m_axis_tready_i stays high.
module a64_register_operand_field_map
  import a64rofm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [31:0] instr_word, [36:32] replacement_register, [39:37] zero
  input  logic [39:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] recognised, [3:1] pc_kind, [5:4] hazard_kind, [36:6] registers_used,
  // [39:37] x18_count, [41:40] rd_role, [43:42] rn_role, [45:44] ra_role,
  // [47:46] rm_role, [49:48] role_union, [81:50] rewritten_word, [87:82] zero
  output logic [87:0] m_axis_tdata_o
);

  // stage control
  logic a_valid_q, b_valid_q, c_valid_q;
  logic a_adv, b_adv, c_adv;

  assign c_adv           = !c_valid_q || m_axis_tready_i;
  assign b_adv           = !b_valid_q || c_adv;
  assign a_adv           = !a_valid_q || b_adv;
  assign s_axis_tready_o = a_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_adv) a_valid_q <= s_axis_tvalid_i;
      if (b_adv) b_valid_q <= a_valid_q;
      if (c_adv) c_valid_q <= b_valid_q;
    end
  end

  // stage A: class decode
  logic [WORD_W-1:0] in_word;
  logic [REG_W-1:0]  in_rep;
  dec_t              a_dec_d;

  assign in_word = s_axis_tdata_i[WORD_W-1:0];
  assign in_rep  = s_axis_tdata_i[WORD_W +: REG_W];
  assign a_dec_d = decode_word(in_word);

  logic [WORD_W-1:0] a_word_q;
  logic [REG_W-1:0]  a_rep_q;
  dec_t              a_dec_q;

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      a_word_q <= in_word;
      a_rep_q  <= in_rep;
      a_dec_q  <= a_dec_d;
    end
  end

  // stage B: register mask, x18 roles
  logic [NUM_GPR-1:0]        b_used_d;
  logic [NUM_SLOTS-1:0][1:0] b_role_d;
  logic [2:0]                b_count_d;

  always_comb begin
    logic [REG_W-1:0] r;
    b_used_d  = '0;
    b_role_d  = '0;
    b_count_d = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      r = a_word_q[SLOT_LSB[i] +: REG_W];
      if (a_dec_q.req[i] != ROLE_NONE && r != REG_ZR_SP) begin
        b_used_d = b_used_d | (NUM_GPR'(1) << r);
        if (r == REG_X18) begin
          b_role_d[i] = a_dec_q.req[i];
          b_count_d   = b_count_d + 3'd1;
        end
      end
    end
  end

  logic [WORD_W-1:0]         b_word_q;
  logic [REG_W-1:0]          b_rep_q;
  logic                      b_ok_q;
  pc_kind_e                  b_pc_q;
  hz_kind_e                  b_hz_q;
  logic [NUM_GPR-1:0]        b_used_q;
  logic [NUM_SLOTS-1:0][1:0] b_role_q;
  logic [2:0]                b_count_q;

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      b_word_q  <= a_word_q;
      b_rep_q   <= a_rep_q;
      b_ok_q    <= a_dec_q.ok;
      b_pc_q    <= a_dec_q.pc;
      b_hz_q    <= a_dec_q.hz;
      b_used_q  <= b_used_d;
      b_role_q  <= b_role_d;
      b_count_q <= b_count_d;
    end
  end

  // stage C: rewrite and output register
  logic [WORD_W-1:0] c_rw_d;
  logic [1:0]        c_union_d;

  always_comb begin
    c_rw_d    = b_word_q;
    c_union_d = ROLE_NONE;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (b_role_q[i] != ROLE_NONE) c_rw_d[SLOT_LSB[i] +: REG_W] = b_rep_q;
      c_union_d = c_union_d | b_role_q[i];
    end
  end

  logic                      c_ok_q;
  pc_kind_e                  c_pc_q;
  hz_kind_e                  c_hz_q;
  logic [NUM_GPR-1:0]        c_used_q;
  logic [NUM_SLOTS-1:0][1:0] c_role_q;
  logic [2:0]                c_count_q;
  logic [1:0]                c_union_q;
  logic [WORD_W-1:0]         c_rw_q;

  always_ff @(posedge clk_i) begin
    if (c_adv) begin
      c_ok_q    <= b_ok_q;
      c_pc_q    <= b_pc_q;
      c_hz_q    <= b_hz_q;
      c_used_q  <= b_used_q;
      c_role_q  <= b_role_q;
      c_count_q <= b_count_q;
      c_union_q <= c_union_d;
      c_rw_q    <= c_rw_d;
    end
  end

  assign m_axis_tvalid_o = c_valid_q;
  assign m_axis_tdata_o  = {6'd0, c_rw_q, c_union_q,
                            c_role_q[SLOT_RM], c_role_q[SLOT_RA],
                            c_role_q[SLOT_RN], c_role_q[SLOT_RD],
                            c_count_q, c_used_q, c_hz_q, c_pc_q, c_ok_q};

`ifndef SYNTHESIS
  // a refused word reports nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q && !c_ok_q |-> c_used_q == '0 && c_count_q == 3'd0 &&
      c_pc_q == PK_NONE && c_hz_q == HZ_NONE && c_union_q == ROLE_NONE)
    else $error("refused word carries nonzero fields");

  // any x18 slot must also show up in the register mask
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q && c_count_q != 3'd0 |-> c_used_q[REG_X18] && c_union_q != ROLE_NONE)
    else $error("x18 slot counted but not in register mask");

  // a stalled middle stage keeps its beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && !c_adv |=> b_valid_q && $stable(b_word_q) && $stable(b_role_q))
    else $error("stage B beat lost under stall");
`endif

endmodule
